>>> hdl/tmpr_pkg.sv
// Shared types, constants and helpers of the text-mode pixel renderer.
`default_nettype none

package tmpr_pkg;

  // Default geometry of the text screen and the font.
  localparam int unsigned TEXT_COLUMNS_DEF = 80;
  localparam int unsigned TEXT_ROWS_DEF    = 25;
  localparam int unsigned CELL_WIDTH_DEF   = 8;
  localparam int unsigned CELL_HEIGHT_DEF  = 16;
  localparam int unsigned FONT_FIRST_DEF   = 32;
  localparam int unsigned FONT_LAST_DEF    = 126;

  // Glyph grid.
  localparam int unsigned GLYPH_W = 5;
  localparam int unsigned GLYPH_H = 7;

  // Field widths.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned GIDX_W   = 7;
  localparam int unsigned GLINE_W  = 3;
  localparam int unsigned PIX_X_W  = 10;
  localparam int unsigned PIX_Y_W  = 9;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned GPOS_W   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CELL  = 2'd0,
    OP_FONT  = 2'd1,
    OP_PIXEL = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Address width of a store of the given depth, at least one bit.
  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tmpr_locate.sv
// Pixel-to-cell locator: cell column and row by reciprocal multiply, frame check.
`default_nettype none

module tmpr_locate import tmpr_pkg::*; #(
  parameter int unsigned TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int unsigned CELL_WIDTH   = CELL_WIDTH_DEF,
  parameter int unsigned CELL_HEIGHT  = CELL_HEIGHT_DEF
) (
  input  logic [PIX_X_W-1:0] pixel_x_i,
  input  logic [PIX_Y_W-1:0] pixel_y_i,
  output logic [PIX_X_W-1:0] cell_x_o,
  output logic [PIX_Y_W-1:0] cell_y_o,
  output logic               in_frame_o
);

  localparam int unsigned FRAME_W = TEXT_COLUMNS * CELL_WIDTH;
  localparam int unsigned FRAME_H = TEXT_ROWS * CELL_HEIGHT;

  // Exact floor division for any dividend below 2**n: M = ceil(2**(n+l) / C).
  localparam int unsigned SX   = PIX_X_W + $clog2(CELL_WIDTH);
  localparam int unsigned MX   = ((2 ** SX) + CELL_WIDTH - 1) / CELL_WIDTH;
  localparam int unsigned XP_W = PIX_X_W + SX + 2;
  localparam int unsigned SY   = PIX_Y_W + $clog2(CELL_HEIGHT);
  localparam int unsigned MY   = ((2 ** SY) + CELL_HEIGHT - 1) / CELL_HEIGHT;
  localparam int unsigned YP_W = PIX_Y_W + SY + 2;

  logic [XP_W-1:0] prod_x;
  logic [YP_W-1:0] prod_y;

  assign prod_x = XP_W'(pixel_x_i) * XP_W'(MX);
  assign prod_y = YP_W'(pixel_y_i) * YP_W'(MY);

  assign cell_x_o   = prod_x[SX +: PIX_X_W];
  assign cell_y_o   = prod_y[SY +: PIX_Y_W];
  assign in_frame_o = (32'(pixel_x_i) < FRAME_W) && (32'(pixel_y_i) < FRAME_H);

endmodule

`default_nettype wire

>>> hdl/tmpr_text_ram.sv
// Character and attribute store with a zeroing sweep after reset.
`default_nettype none

module tmpr_text_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned AW     = 11,
  parameter int unsigned DW     = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o,
  output logic          busy_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          busy_q, busy_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  // Single port: sweep writes zero, otherwise the pipeline writes or reads.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

>>> hdl/tmpr_font_ram.sv
// Glyph row store, one five-bit row per entry.
`default_nettype none

module tmpr_font_ram import tmpr_pkg::*; #(
  parameter int unsigned DEPTH = 665,
  parameter int unsigned AW    = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [GLYPH_W-1:0] wdata_i,
  output logic [GLYPH_W-1:0] rdata_o
);

  logic [GLYPH_W-1:0] mem_q [DEPTH];
  logic [GLYPH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/tmpr_shade.sv
// Color pick: glyph bit selects foreground or background palette entry.
`default_nettype none

module tmpr_shade import tmpr_pkg::*; (
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              fg_i,
  input  logic              in_frame_i,
  output rgb_t              rgb_o
);

  function automatic rgb_t palette_lookup(logic [3:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd0,   8'd0,   8'd170};
      4'd2:    c = '{8'd0,   8'd170, 8'd0};
      4'd3:    c = '{8'd0,   8'd170, 8'd170};
      4'd4:    c = '{8'd170, 8'd0,   8'd0};
      4'd5:    c = '{8'd170, 8'd0,   8'd170};
      4'd6:    c = '{8'd170, 8'd85,  8'd0};
      4'd7:    c = '{8'd170, 8'd170, 8'd170};
      4'd8:    c = '{8'd85,  8'd85,  8'd85};
      4'd9:    c = '{8'd85,  8'd85,  8'd255};
      4'd10:   c = '{8'd85,  8'd255, 8'd85};
      4'd11:   c = '{8'd85,  8'd255, 8'd255};
      4'd12:   c = '{8'd255, 8'd85,  8'd85};
      4'd13:   c = '{8'd255, 8'd85,  8'd255};
      4'd14:   c = '{8'd255, 8'd255, 8'd85};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  logic [3:0] color_idx;

  assign color_idx = fg_i ? attr_i[3:0] : attr_i[7:4];
  // Pixels outside the frame draw black.
  assign rgb_o     = in_frame_i ? palette_lookup(color_idx) : '0;

endmodule

`default_nettype wire

>>> hdl/text_mode_pixel_renderer.sv
// Top level of the text-mode pixel renderer: pipeline around text and font stores.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | opcode, cell, glyph, pixel fields
//  out     | source    | out_valid_o / out_ready_i | red, green, blue of a queried pixel
//
// One word enters per clock while in_ready_o is high. A pixel query passes the
// input register, text store read, font store read and output register in turn.
// After reset the text store is zeroed one entry per cycle, all TEXT_ROWS *
// TEXT_COLUMNS entries (2000 by default), with in_ready_o low during the sweep.
// A color word held in the output register while out_ready_i is low stalls
// the pipeline only when the third stage also holds a color word.
`default_nettype none

module text_mode_pixel_renderer import tmpr_pkg::*; #(
  parameter int unsigned TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int unsigned CELL_WIDTH   = CELL_WIDTH_DEF,
  parameter int unsigned CELL_HEIGHT  = CELL_HEIGHT_DEF,
  parameter int unsigned FONT_FIRST   = FONT_FIRST_DEF,
  parameter int unsigned FONT_LAST    = FONT_LAST_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [ROW_W-1:0]    cell_row_i,
  input  logic [COL_W-1:0]    cell_col_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [ATTR_W-1:0]   attr_byte_i,
  input  logic [GIDX_W-1:0]   glyph_index_i,
  input  logic [GLINE_W-1:0]  glyph_line_i,
  input  logic [GLYPH_W-1:0]  glyph_bits_i,
  input  logic [PIX_X_W-1:0]  pixel_x_i,
  input  logic [PIX_Y_W-1:0]  pixel_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAN_W-1:0]   red_o,
  output logic [CHAN_W-1:0]   green_o,
  output logic [CHAN_W-1:0]   blue_o
);

  localparam int unsigned CELL_COUNT  = TEXT_ROWS * TEXT_COLUMNS;
  localparam int unsigned TA_W        = addr_w(CELL_COUNT);
  localparam int unsigned GLYPH_COUNT =
    (FONT_LAST >= FONT_FIRST) ? (FONT_LAST - FONT_FIRST + 1) : 0;
  localparam int unsigned FONT_DEPTH  =
    (GLYPH_COUNT > 0) ? (GLYPH_COUNT * GLYPH_H) : 1;
  localparam int unsigned FA_W        = addr_w(FONT_DEPTH);
  localparam int unsigned TD_W        = CHAR_W + ATTR_W;
  localparam int unsigned OX_W        = $clog2(CELL_WIDTH);
  localparam int unsigned OY_W        = $clog2(CELL_HEIGHT);

  // Glyph scaling floor(o*K/C) as o * (K*ceil(2**S/C)) >> S, exact for o*K < 256.
  localparam int unsigned SGX   = 8 + $clog2(CELL_WIDTH);
  localparam int unsigned KGX   = GLYPH_W * (((2 ** SGX) + CELL_WIDTH - 1) / CELL_WIDTH);
  localparam int unsigned GXP_W = OX_W + SGX + 4;
  localparam int unsigned SGY   = 8 + $clog2(CELL_HEIGHT);
  localparam int unsigned KGY   = GLYPH_H * (((2 ** SGY) + CELL_HEIGHT - 1) / CELL_HEIGHT);
  localparam int unsigned GYP_W = OY_W + SGY + 4;

  // ---------------------------------------------------------------------------
  // Flow control: advance every stage together unless a color word in the
  // last stage cannot move into a full, unread output register.
  // ---------------------------------------------------------------------------
  logic adv;
  logic clearing;
  logic in_acc;
  logic out_valid_q;
  rgb_t out_rgb_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s3_pixel_q;

  assign adv        = !(s3_valid_q && s3_pixel_q && out_valid_q && !out_ready_i);
  assign in_ready_o = adv && !clearing;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Stage 0 -> 1: locate the pixel's cell while the word is captured.
  // ---------------------------------------------------------------------------
  logic [PIX_X_W-1:0] loc_cx;
  logic [PIX_Y_W-1:0] loc_cy;
  logic               loc_frame;

  tmpr_locate #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .CELL_WIDTH   (CELL_WIDTH),
    .CELL_HEIGHT  (CELL_HEIGHT)
  ) u_locate (
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .cell_x_o   (loc_cx),
    .cell_y_o   (loc_cy),
    .in_frame_o (loc_frame)
  );

  logic               s1_cell_q, s1_font_q, s1_pixel_q, s1_frame_q;
  logic [PIX_X_W-1:0] s1_x_q, s1_cx_q;
  logic [PIX_Y_W-1:0] s1_y_q, s1_cy_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [CHAR_W-1:0]  s1_char_q;
  logic [ATTR_W-1:0]  s1_attr_q;
  logic [GIDX_W-1:0]  s1_gidx_q;
  logic [GLINE_W-1:0] s1_gline_q;
  logic [GLYPH_W-1:0] s1_gbits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
    end
  end

  // Capture the word; opcode three sets no flag and passes as a bubble.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cell_q  <= (opcode_i == OP_CELL);
      s1_font_q  <= (opcode_i == OP_FONT);
      s1_pixel_q <= (opcode_i == OP_PIXEL);
      s1_frame_q <= loc_frame;
      s1_x_q     <= pixel_x_i;
      s1_y_q     <= pixel_y_i;
      s1_cx_q    <= loc_cx;
      s1_cy_q    <= loc_cy;
      s1_row_q   <= cell_row_i;
      s1_col_q   <= cell_col_i;
      s1_char_q  <= char_code_i;
      s1_attr_q  <= attr_byte_i;
      s1_gidx_q  <= glyph_index_i;
      s1_gline_q <= glyph_line_i;
      s1_gbits_q <= glyph_bits_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: text store access. Cell writes and pixel reads both land here,
  // so a read always sees every earlier write.
  // ---------------------------------------------------------------------------
  logic               cell_ok;
  logic               font_ok;
  logic [TA_W-1:0]    ta_row, ta_col, ta_addr;
  logic               ta_we, ta_re;
  logic [TD_W-1:0]    ta_rdata;
  logic [PIX_X_W-1:0] rem_x;
  logic [PIX_Y_W-1:0] rem_y;
  logic [FA_W-1:0]    fw_addr;

  assign cell_ok = (32'(s1_row_q) < TEXT_ROWS) && (32'(s1_col_q) < TEXT_COLUMNS);
  assign font_ok = (32'(s1_gidx_q) < GLYPH_COUNT) && (32'(s1_gline_q) < GLYPH_H);

  assign ta_row  = s1_cell_q ? TA_W'(s1_row_q) : TA_W'(s1_cy_q);
  assign ta_col  = s1_cell_q ? TA_W'(s1_col_q) : TA_W'(s1_cx_q);
  assign ta_addr = ta_row * TA_W'(TEXT_COLUMNS) + ta_col;
  assign ta_we   = adv && s1_valid_q && s1_cell_q && cell_ok;
  assign ta_re   = adv && s1_valid_q && s1_pixel_q && s1_frame_q;

  // Offset inside the cell.
  assign rem_x   = s1_x_q - PIX_X_W'(s1_cx_q * PIX_X_W'(CELL_WIDTH));
  assign rem_y   = s1_y_q - PIX_Y_W'(s1_cy_q * PIX_Y_W'(CELL_HEIGHT));

  assign fw_addr = FA_W'(s1_gidx_q) * FA_W'(GLYPH_H) + FA_W'(s1_gline_q);

  tmpr_text_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (TA_W),
    .DW    (TD_W)
  ) u_text_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ta_we),
    .re_i    (ta_re),
    .addr_i  (ta_addr),
    .wdata_i ({s1_attr_q, s1_char_q}),
    .rdata_o (ta_rdata),
    .busy_o  (clearing)
  );

  logic               s2_pixel_q, s2_frame_q, s2_fwe_q;
  logic [OX_W-1:0]    s2_ox_q;
  logic [OY_W-1:0]    s2_oy_q;
  logic [FA_W-1:0]    s2_faddr_q;
  logic [GLYPH_W-1:0] s2_fbits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pixel_q <= s1_pixel_q;
      s2_frame_q <= s1_frame_q;
      s2_fwe_q   <= s1_font_q && font_ok;
      s2_ox_q    <= rem_x[OX_W-1:0];
      s2_oy_q    <= rem_y[OY_W-1:0];
      s2_faddr_q <= fw_addr;
      s2_fbits_q <= s1_gbits_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: font store access. Font writes and glyph reads both land here.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0]  s2_char;
  logic [ATTR_W-1:0]  s2_attr;
  logic               glyph_ok;
  logic [GXP_W-1:0]   gx_prod;
  logic [GYP_W-1:0]   gy_prod;
  logic [GPOS_W-1:0]  gx, gy;
  logic [FA_W-1:0]    fr_addr;
  logic               fa_we, fa_re;
  logic [GLYPH_W-1:0] fa_rdata;

  assign s2_char  = ta_rdata[CHAR_W-1:0];
  assign s2_attr  = ta_rdata[TD_W-1:CHAR_W];
  // Characters outside the font draw as background.
  assign glyph_ok = (32'(s2_char) >= FONT_FIRST) && (32'(s2_char) <= FONT_LAST);

  assign gx_prod  = GXP_W'(s2_ox_q) * GXP_W'(KGX);
  assign gy_prod  = GYP_W'(s2_oy_q) * GYP_W'(KGY);
  assign gx       = gx_prod[SGX +: GPOS_W];
  assign gy       = gy_prod[SGY +: GPOS_W];

  assign fr_addr  = FA_W'(s2_char - CHAR_W'(FONT_FIRST)) * FA_W'(GLYPH_H) + FA_W'(gy);
  assign fa_we    = adv && s2_valid_q && s2_fwe_q;
  assign fa_re    = adv && s2_valid_q && s2_pixel_q && s2_frame_q && glyph_ok;

  tmpr_font_ram #(
    .DEPTH (FONT_DEPTH),
    .AW    (FA_W)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (fa_we),
    .re_i    (fa_re),
    .addr_i  (fa_we ? s2_faddr_q : fr_addr),
    .wdata_i (s2_fbits_q),
    .rdata_o (fa_rdata)
  );

  logic               s3_frame_q, s3_glyph_q;
  logic [GPOS_W-1:0]  s3_gx_q;
  logic [ATTR_W-1:0]  s3_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_pixel_q <= s2_pixel_q;
      s3_frame_q <= s2_frame_q;
      s3_glyph_q <= glyph_ok;
      s3_gx_q    <= gx;
      s3_attr_q  <= s2_attr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the glyph bit (MSB is the leftmost column) and the color.
  // ---------------------------------------------------------------------------
  logic fg_bit;
  rgb_t pix_rgb;

  assign fg_bit = s3_glyph_q && fa_rdata[GPOS_W'(GLYPH_W - 1) - s3_gx_q];

  tmpr_shade u_shade (
    .attr_i     (s3_attr_q),
    .fg_i       (fg_bit),
    .in_frame_i (s3_frame_q),
    .rgb_o      (pix_rgb)
  );

  // Output register: load a new color word, or drop the old one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s3_valid_q && s3_pixel_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q && s3_pixel_q) begin
      out_rgb_q <= pix_rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_rgb_q.red;
  assign green_o     = out_rgb_q.green;
  assign blue_o      = out_rgb_q.blue;

endmodule

`default_nettype wire
